@@ sv/buddy_page_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared assertion forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define BPA_ASSERT_IMP(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define BPA_ASSERT_NXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ sv/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Field widths, operation and status codes, and the free-list command type.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int DEF_MAX_PAGES = 4096;
   localparam int DEF_TOP_RANK  = 16;

   localparam int FUNC_W   = 3;
   localparam int RANK_W   = 5;
   localparam int PAGE_W   = 13;
   localparam int STATUS_W = 2;
   localparam int BLOCK_W  = 12;
   localparam int VALUE_W  = 13;
   localparam int COUNT_W  = 13;
   localparam int CFG_W    = 13;

   localparam logic [FUNC_W-1:0] FUNC_INIT   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_QRANK  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QCOUNT = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVAL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPC = 2'd2;

   // Command to the free-list head and count registers.
   typedef struct packed {
      logic              clear;
      logic              push;
      logic              pull;
      logic              set_head;
      logic [RANK_W-1:0] rank;
   } list_cmd_type;

endpackage

@@ sv/buddy_page_allocator.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator
// Page pool manager with per-rank free lists, block split and buddy merge.
// ----------------------------------------------------------------------------
// Usage: write the pool size on the csr_ channel (always ready), then send an
// init request on req_. Each request transfer on req_ yields exactly one
// response transfer on rsp_. Requests are taken one at a time; req_tready is
// high only while the sequencer is idle.
// Latency depends on the operation. Allocate and free update the free lists and
// rewrite every page of the affected block in the page-info memory, one page
// at a time through its single write port; a full init rewrites every pool
// page once and steps down through the ranks as the remaining pages shrink.
// Reset empties all free lists and sets the pool size to zero, so every free
// or rank query is rejected until an init. The memories need no clearing.
// A stalled rsp_ holds the response in its output register; the sequencer
// finishes the next request and then waits with its result until the output
// register is taken.
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_macros.svh"

module buddy_page_allocator import bpa_pkg::*; #(
   parameter int MAX_PAGES = DEF_MAX_PAGES,
   parameter int TOP_RANK  = DEF_TOP_RANK
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,   // req_rank[4:0], page_index[17:5]
   input  logic [2:0]       req_tuser,   // func[2:0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,   // status[1:0], block_page[13:2], value[26:14]
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int LW = $clog2(MAX_PAGES + 1);
   localparam int SW = ((LW > TOP_RANK) ? LW : TOP_RANK) + 1;
   localparam logic [LW-1:0] NULL_LINK = LW'(MAX_PAGES);
   localparam int PIW = RANK_W + 1;

   localparam logic [4:0] S_IDLE        = 5'd0;
   localparam logic [4:0] S_INIT_LOOP   = 5'd1;
   localparam logic [4:0] S_INIT_PUSH   = 5'd2;
   localparam logic [4:0] S_INIT_NEXT   = 5'd3;
   localparam logic [4:0] S_ALLOC_SPLIT = 5'd4;
   localparam logic [4:0] S_ALLOC_PUSH  = 5'd5;
   localparam logic [4:0] S_FREE_CHK    = 5'd6;
   localparam logic [4:0] S_FREE_BUD    = 5'd7;
   localparam logic [4:0] S_FREE_BUDCHK = 5'd8;
   localparam logic [4:0] S_FREE_MERGE  = 5'd9;
   localparam logic [4:0] S_QRANK       = 5'd10;
   localparam logic [4:0] S_MARK        = 5'd11;
   localparam logic [4:0] S_PUSH1       = 5'd12;
   localparam logic [4:0] S_PUSH2       = 5'd13;
   localparam logic [4:0] S_RM1         = 5'd14;
   localparam logic [4:0] S_RM2         = 5'd15;
   localparam logic [4:0] S_DONE        = 5'd16;

   function automatic logic [SW-1:0] rank_pages(input logic [RANK_W-1:0] r);
      logic [RANK_W-1:0] e;
      e = r - 1'b1;
      return SW'(1) << e;
   endfunction

   // Request fields.
   logic [FUNC_W-1:0] req_func;
   logic [RANK_W-1:0] req_rank;
   logic [SW-1:0]     req_page;
   assign req_func = req_tuser;
   assign req_rank = req_tdata[4:0];
   assign req_page = SW'(req_tdata[17:5]);

   logic [4:0]          state_ff, state_in, ret_ff, ret_in;
   logic [CFG_W-1:0]    pool_pages_ff;
   logic [LW-1:0]       pool_size_ff, pool_size_in;
   logic [SW-1:0]       cur_off_ff, cur_off_in;
   logic [RANK_W-1:0]   cur_rank_ff, cur_rank_in;
   logic [RANK_W-1:0]   goal_rank_ff, goal_rank_in;
   logic [LW-1:0]       left_ff, left_in;
   logic [SW-1:0]       sub_off_ff, sub_off_in;
   logic [RANK_W-1:0]   sub_rank_ff, sub_rank_in;
   logic [SW-1:0]       mark_ptr_ff, mark_ptr_in, mark_end_ff, mark_end_in;
   logic [RANK_W-1:0]   mark_rank_ff, mark_rank_in;
   logic                mark_used_ff, mark_used_in;
   logic [LW-1:0]       save_head_ff, save_head_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [BLOCK_W-1:0]  res_block_ff, res_block_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [BLOCK_W-1:0]  rsp_block_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic                rsp_load;

   // Memory ports.
   logic           pi_we;
   logic [AW-1:0]  pi_waddr, pi_raddr;
   logic [PIW-1:0] pi_wdata, pi_rdata;
   logic           nx_we, pv_we;
   logic [AW-1:0]  nx_waddr, pv_waddr;
   logic [LW-1:0]  nx_wdata, pv_wdata, nx_rdata, pv_rdata;

   // Free-list registers.
   list_cmd_type       lcmd;
   logic [LW-1:0]      lcmd_head;
   logic [RANK_W-1:0]  look_rank;
   logic [LW-1:0]      look_head, find_head;
   logic [COUNT_W-1:0] look_count;
   logic               find_hit;
   logic [RANK_W-1:0]  find_rank;

   // Scratch values of the sequencer.
   logic [LW-1:0]       clamp_pages;
   logic [SW-1:0]       n_cur, bud, half;
   logic [RANK_W-1:0]   r_rd, r_dn;
   logic [SW-1:0]       sub_base;

   assign clamp_pages = (32'(pool_pages_ff) > 32'(MAX_PAGES)) ? NULL_LINK
                                                            : LW'(pool_pages_ff);
   assign n_cur    = rank_pages(cur_rank_ff);
   assign bud      = cur_off_ff ^ n_cur;
   assign r_rd     = pi_rdata[RANK_W-1:0];
   assign r_dn     = cur_rank_ff - 1'b1;
   assign half     = cur_off_ff + rank_pages(r_dn);
   assign sub_base = sub_off_ff;

   assign look_rank = (state_ff == S_IDLE) ? req_rank : sub_rank_ff;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      pool_size_in  = pool_size_ff;
      cur_off_in    = cur_off_ff;
      cur_rank_in   = cur_rank_ff;
      goal_rank_in  = goal_rank_ff;
      left_in       = left_ff;
      sub_off_in    = sub_off_ff;
      sub_rank_in   = sub_rank_ff;
      mark_ptr_in   = mark_ptr_ff;
      mark_end_in   = mark_end_ff;
      mark_rank_in  = mark_rank_ff;
      mark_used_in  = mark_used_ff;
      save_head_in  = save_head_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      res_value_in  = res_value_ff;
      pi_we         = 1'b0;
      pi_waddr      = mark_ptr_ff[AW-1:0];
      pi_wdata      = {mark_used_ff, mark_rank_ff};
      pi_raddr      = req_page[AW-1:0];
      nx_we         = 1'b0;
      nx_waddr      = sub_base[AW-1:0];
      nx_wdata      = look_head;
      pv_we         = 1'b0;
      pv_waddr      = sub_base[AW-1:0];
      pv_wdata      = NULL_LINK;
      lcmd          = '0;
      lcmd_head     = sub_base[LW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               res_status_in = ST_INVAL;
               res_block_in  = '0;
               res_value_in  = '0;
               state_in      = S_DONE;
               case (req_func)
                  FUNC_INIT: begin
                     lcmd.clear   = 1'b1;
                     pool_size_in = clamp_pages;
                     cur_off_in   = '0;
                     left_in      = clamp_pages;
                     cur_rank_in  = RANK_W'(TOP_RANK);
                     state_in     = S_INIT_LOOP;
                  end
                  FUNC_ALLOC: begin
                     if (req_rank >= RANK_W'(1) && req_rank <= RANK_W'(TOP_RANK)) begin
                        if (!find_hit) begin
                           res_status_in = ST_NOSPC;
                        end else begin
                           cur_off_in   = SW'(find_head);
                           cur_rank_in  = find_rank;
                           goal_rank_in = req_rank;
                           sub_off_in   = SW'(find_head);
                           sub_rank_in  = find_rank;
                           ret_in       = S_ALLOC_SPLIT;
                           state_in     = S_RM1;
                        end
                     end
                  end
                  FUNC_FREE: begin
                     if (req_page < SW'(pool_size_ff)) begin
                        cur_off_in = req_page;
                        state_in   = S_FREE_CHK;
                     end
                  end
                  FUNC_QRANK: begin
                     if (req_page < SW'(pool_size_ff)) begin
                        state_in = S_QRANK;
                     end
                  end
                  FUNC_QCOUNT: begin
                     if (req_rank >= RANK_W'(1) && req_rank <= RANK_W'(TOP_RANK)) begin
                        res_status_in = ST_OK;
                        res_value_in  = VALUE_W'(look_count);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_INIT_LOOP: begin
            if (cur_rank_ff == '0 || left_ff == '0) begin
               res_status_in = ST_OK;
               state_in      = S_DONE;
            end else if (SW'(left_ff) >= n_cur) begin
               mark_ptr_in  = cur_off_ff;
               mark_end_in  = cur_off_ff + n_cur;
               mark_rank_in = cur_rank_ff;
               mark_used_in = 1'b0;
               ret_in       = S_INIT_PUSH;
               state_in     = S_MARK;
            end else begin
               cur_rank_in = r_dn;
            end
         end

         S_INIT_PUSH: begin
            sub_off_in  = cur_off_ff;
            sub_rank_in = cur_rank_ff;
            ret_in      = S_INIT_NEXT;
            state_in    = S_PUSH1;
         end

         S_INIT_NEXT: begin
            cur_off_in = cur_off_ff + n_cur;
            left_in    = left_ff - LW'(n_cur);
            state_in   = S_INIT_LOOP;
         end

         S_ALLOC_SPLIT: begin
            if (cur_rank_ff > goal_rank_ff) begin
               // Split off the upper half and give it back to its list.
               cur_rank_in  = r_dn;
               sub_off_in   = half;
               sub_rank_in  = r_dn;
               mark_ptr_in  = half;
               mark_end_in  = half + rank_pages(r_dn);
               mark_rank_in = r_dn;
               mark_used_in = 1'b0;
               ret_in       = S_ALLOC_PUSH;
            end else begin
               mark_ptr_in   = cur_off_ff;
               mark_end_in   = cur_off_ff + rank_pages(goal_rank_ff);
               mark_rank_in  = goal_rank_ff;
               mark_used_in  = 1'b1;
               res_status_in = ST_OK;
               res_block_in  = cur_off_ff[BLOCK_W-1:0];
               ret_in        = S_DONE;
            end
            state_in = S_MARK;
         end

         S_ALLOC_PUSH: begin
            ret_in   = S_ALLOC_SPLIT;
            state_in = S_PUSH1;
         end

         S_FREE_CHK: begin
            if (!pi_rdata[RANK_W] || r_rd == '0 || r_rd > RANK_W'(TOP_RANK) ||
                (cur_off_ff & (rank_pages(r_rd) - 1'b1)) != '0) begin
               state_in = S_DONE;
            end else begin
               cur_rank_in  = r_rd;
               mark_ptr_in  = cur_off_ff;
               mark_end_in  = cur_off_ff + rank_pages(r_rd);
               mark_rank_in = r_rd;
               mark_used_in = 1'b0;
               ret_in       = S_FREE_BUD;
               state_in     = S_MARK;
            end
         end

         S_FREE_BUD: begin
            pi_raddr = bud[AW-1:0];
            if (cur_rank_ff >= RANK_W'(TOP_RANK) || bud + n_cur > SW'(pool_size_ff) ||
                bud >= SW'(MAX_PAGES)) begin
               sub_off_in    = cur_off_ff;
               sub_rank_in   = cur_rank_ff;
               res_status_in = ST_OK;
               ret_in        = S_DONE;
               state_in      = S_PUSH1;
            end else begin
               state_in = S_FREE_BUDCHK;
            end
         end

         S_FREE_BUDCHK: begin
            sub_rank_in = cur_rank_ff;
            if (pi_rdata[RANK_W] || r_rd != cur_rank_ff) begin
               sub_off_in    = cur_off_ff;
               res_status_in = ST_OK;
               ret_in        = S_DONE;
            end else begin
               sub_off_in = bud;
               ret_in     = S_FREE_MERGE;
            end
            state_in = (pi_rdata[RANK_W] || r_rd != cur_rank_ff) ? S_PUSH1 : S_RM1;
         end

         S_FREE_MERGE: begin
            cur_off_in   = cur_off_ff & ~n_cur;
            cur_rank_in  = cur_rank_ff + 1'b1;
            mark_ptr_in  = cur_off_ff & ~n_cur;
            mark_end_in  = (cur_off_ff & ~n_cur) + (n_cur << 1);
            mark_rank_in = cur_rank_ff + 1'b1;
            mark_used_in = 1'b0;
            ret_in       = S_FREE_BUD;
            state_in     = S_MARK;
         end

         S_QRANK: begin
            res_status_in = ST_OK;
            res_value_in  = VALUE_W'(r_rd);
            state_in      = S_DONE;
         end

         S_MARK: begin
            if (mark_ptr_ff < mark_end_ff && mark_ptr_ff < SW'(MAX_PAGES)) begin
               pi_we       = 1'b1;
               mark_ptr_in = mark_ptr_ff + 1'b1;
            end else begin
               state_in = ret_ff;
            end
         end

         S_PUSH1: begin
            nx_we        = 1'b1;
            pv_we        = 1'b1;
            lcmd.push    = 1'b1;
            lcmd.rank    = sub_rank_ff;
            save_head_in = look_head;
            state_in     = S_PUSH2;
         end

         S_PUSH2: begin
            pv_waddr = save_head_ff[AW-1:0];
            pv_wdata = sub_base[LW-1:0];
            pv_we    = (save_head_ff != NULL_LINK);
            state_in = ret_ff;
         end

         S_RM1: begin
            state_in = S_RM2;
         end

         S_RM2: begin
            // Unlink the entry whose links were read in the previous cycle.
            lcmd.pull = 1'b1;
            lcmd.rank = sub_rank_ff;
            if (pv_rdata != NULL_LINK) begin
               nx_we    = 1'b1;
               nx_waddr = pv_rdata[AW-1:0];
               nx_wdata = nx_rdata;
            end else begin
               lcmd.set_head = 1'b1;
               lcmd_head     = nx_rdata;
            end
            pv_we    = (nx_rdata != NULL_LINK);
            pv_waddr = nx_rdata[AW-1:0];
            pv_wdata = pv_rdata;
            state_in = ret_ff;
         end

         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pool_pages_ff <= '0;
         pool_size_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_size_ff <= pool_size_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            pool_pages_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      cur_off_ff    <= cur_off_in;
      cur_rank_ff   <= cur_rank_in;
      goal_rank_ff  <= goal_rank_in;
      left_ff       <= left_in;
      sub_off_ff    <= sub_off_in;
      sub_rank_ff   <= sub_rank_in;
      mark_ptr_ff   <= mark_ptr_in;
      mark_end_ff   <= mark_end_in;
      mark_rank_ff  <= mark_rank_in;
      mark_used_ff  <= mark_used_in;
      save_head_ff  <= save_head_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      res_value_ff  <= res_value_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_block_ff  <= res_block_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   bpa_ram #(.WIDTH(PIW), .DEPTH(MAX_PAGES), .AW(AW)) u_page_info (
      .clock (clock),
      .we    (pi_we),
      .waddr (pi_waddr),
      .wdata (pi_wdata),
      .raddr (pi_raddr),
      .rdata (pi_rdata)
   );

   bpa_ram #(.WIDTH(LW), .DEPTH(MAX_PAGES), .AW(AW)) u_next_link (
      .clock (clock),
      .we    (nx_we),
      .waddr (nx_waddr),
      .wdata (nx_wdata),
      .raddr (sub_base[AW-1:0]),
      .rdata (nx_rdata)
   );

   bpa_ram #(.WIDTH(LW), .DEPTH(MAX_PAGES), .AW(AW)) u_prev_link (
      .clock (clock),
      .we    (pv_we),
      .waddr (pv_waddr),
      .wdata (pv_wdata),
      .raddr (sub_base[AW-1:0]),
      .rdata (pv_rdata)
   );

   bpa_lists #(.TOP_RANK(TOP_RANK), .LW(LW), .NULL_VAL(MAX_PAGES)) u_lists (
      .clock      (clock),
      .reset      (reset),
      .cmd        (lcmd),
      .cmd_head   (lcmd_head),
      .look_rank  (look_rank),
      .look_head  (look_head),
      .look_count (look_count),
      .find_hit   (find_hit),
      .find_rank  (find_rank),
      .find_head  (find_head)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_value_ff, rsp_block_ff, rsp_status_ff};

   `BPA_ASSERT_IMP(a_pool_bound, 1'b1, pool_size_ff <= LW'(MAX_PAGES),
      "pool size exceeds the page count")
   `BPA_ASSERT_IMP(a_pull_nonempty, state_ff == S_RM2, look_count != '0,
      "block removed from an empty free list")
   `BPA_ASSERT_IMP(a_push_no_self, state_ff == S_PUSH1, look_head != sub_base[LW-1:0],
      "block pushed onto a list it already heads")
   `BPA_ASSERT_NXT(a_start_busy, req_tvalid && req_tready, state_ff != S_IDLE,
      "request transfer did not start an operation")

endmodule

@@ sv/bpa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/bpa_lists.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator free-list registers
// Head pointer and block count of every rank, with lookup and a search for
// the smallest non-empty rank at or above a given one.
// ----------------------------------------------------------------------------
module bpa_lists import bpa_pkg::*; #(
   parameter int TOP_RANK = DEF_TOP_RANK,
   parameter int LW       = 13,
   parameter int NULL_VAL = DEF_MAX_PAGES
) (
   input  logic               clock,
   input  logic               reset,
   input  list_cmd_type       cmd,
   input  logic [LW-1:0]      cmd_head,
   input  logic [RANK_W-1:0]  look_rank,
   output logic [LW-1:0]      look_head,
   output logic [COUNT_W-1:0] look_count,
   output logic               find_hit,
   output logic [RANK_W-1:0]  find_rank,
   output logic [LW-1:0]      find_head
);

   localparam logic [LW-1:0] NULL_LINK = LW'(NULL_VAL);

   logic [LW-1:0]      head_ff  [TOP_RANK];
   logic [LW-1:0]      head_in  [TOP_RANK];
   logic [COUNT_W-1:0] count_ff [TOP_RANK];
   logic [COUNT_W-1:0] count_in [TOP_RANK];

   always_comb begin
      for (int i = 0; i < TOP_RANK; i++) begin
         head_in[i]  = head_ff[i];
         count_in[i] = count_ff[i];
         if (cmd.clear) begin
            head_in[i]  = NULL_LINK;
            count_in[i] = '0;
         end else if (cmd.rank == RANK_W'(i + 1)) begin
            if (cmd.push) begin
               head_in[i]  = cmd_head;
               count_in[i] = count_ff[i] + 1'b1;
            end
            if (cmd.pull) begin
               count_in[i] = count_ff[i] - 1'b1;
               if (cmd.set_head) begin
                  head_in[i] = cmd_head;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TOP_RANK; i++) begin
         if (reset) begin
            head_ff[i]  <= NULL_LINK;
            count_ff[i] <= '0;
         end else begin
            head_ff[i]  <= head_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   always_comb begin
      look_head  = NULL_LINK;
      look_count = '0;
      find_hit   = 1'b0;
      find_rank  = '0;
      find_head  = NULL_LINK;
      for (int i = 0; i < TOP_RANK; i++) begin
         if (look_rank == RANK_W'(i + 1)) begin
            look_head  = head_ff[i];
            look_count = count_ff[i];
         end
      end
      // Walk downward so that the lowest qualifying rank wins.
      for (int i = TOP_RANK - 1; i >= 0; i--) begin
         if (RANK_W'(i + 1) >= look_rank && head_ff[i] != NULL_LINK) begin
            find_hit  = 1'b1;
            find_rank = RANK_W'(i + 1);
            find_head = head_ff[i];
         end
      end
   end

endmodule

@@ verif/buddy_page_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives directed and random page requests and checks every response against a
// cycle-free model of the free lists, splits and buddy merges, or a typed row.
// ----------------------------------------------------------------------------
module buddy_page_allocator_tb;
   import bpa_pkg::*;

   localparam int NPAGES   = DEF_MAX_PAGES;
   localparam int NRANKS   = DEF_TOP_RANK;
   localparam int NIL      = NPAGES;
   localparam int IDLE_CAP = 60000;
   localparam logic [FUNC_W-1:0] FUNC_BAD_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_BAD_HI = 3'd7;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [BLOCK_W-1:0]  block_page;
      logic [VALUE_W-1:0]  value;
   } rsp_type;

   typedef struct {
      logic [FUNC_W-1:0]   func;
      logic [RANK_W-1:0]   rank;
      logic [PAGE_W-1:0]   page;
      bit                  typed;
      logic [STATUS_W-1:0] status;
      logic [BLOCK_W-1:0]  block_page;
      logic [VALUE_W-1:0]  value;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [23:0]        req_tdata = '0;  // req_rank[4:0], page_index[17:5]
   logic [2:0]         req_tuser = '0;  // func[2:0]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [31:0]        rsp_tdata;       // status[1:0], block_page[13:2], value[26:14]
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_wdata = '0;

   // Allocator state as the testbench sees it.
   bit       pg_used [NPAGES];
   int       pg_rank [NPAGES];
   int       nxt [NPAGES];
   int       prv [NPAGES];
   int       head [NRANKS];
   int       nfree [NRANKS];
   int       pool_cfg;
   int       pool_sz;

   rsp_type  pending_rsp[$];
   int       live_blocks[$];
   int       errors;
   int       sent;
   int       tx_gap_pct;
   int       rx_gap_pct;
   int       idle_cycles;
   bit       hold_done;
   int       hold_left;

   buddy_page_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int rank_span(int r);
      return 1 << (r - 1);
   endfunction

   function automatic void list_add(int off, int r);
      nxt[off] = head[r-1];
      prv[off] = NIL;
      if (head[r-1] < NIL) prv[head[r-1]] = off;
      head[r-1] = off;
      nfree[r-1]++;
   endfunction

   function automatic void list_drop(int off, int r);
      int n;
      int p;
      n = nxt[off];
      p = prv[off];
      if (p < NIL) nxt[p] = n;
      else head[r-1] = n;
      if (n < NIL) prv[n] = p;
      nfree[r-1]--;
   endfunction

   // A negative use leaves the allocated bits alone and only rewrites ranks.
   function automatic void mark_pages(int off, int r, int use_bit);
      for (int j = off; j < off + rank_span(r) && j < NPAGES; j++) begin
         pg_rank[j] = r;
         if (use_bit >= 0) pg_used[j] = use_bit[0];
      end
   endfunction

   function automatic void clear_pool();
      for (int i = 0; i < NPAGES; i++) begin
         pg_used[i] = 1'b0;
         pg_rank[i] = 0;
      end
      for (int i = 0; i < NRANKS; i++) begin
         head[i]  = NIL;
         nfree[i] = 0;
      end
   endfunction

   function automatic void rebuild_pool();
      int off;
      int left;
      clear_pool();
      pool_sz = (pool_cfg > NPAGES) ? NPAGES : pool_cfg;
      off  = 0;
      left = pool_sz;
      for (int r = NRANKS; r >= 1 && left > 0; r--) begin
         while (left >= rank_span(r)) begin
            mark_pages(off, r, 0);
            list_add(off, r);
            off  += rank_span(r);
            left -= rank_span(r);
         end
      end
   endfunction

   function automatic logic [STATUS_W-1:0] take_block(int want, output int page);
      int r;
      int off;
      page = 0;
      if (want < 1 || want > NRANKS) return ST_INVAL;
      r = want;
      while (r <= NRANKS && head[r-1] >= NIL) r++;
      if (r > NRANKS) return ST_NOSPC;
      off = head[r-1];
      list_drop(off, r);
      while (r > want) begin
         r--;
         mark_pages(off + rank_span(r), r, 0);
         list_add(off + rank_span(r), r);
      end
      mark_pages(off, want, 1);
      page = off;
      return ST_OK;
   endfunction

   function automatic logic [STATUS_W-1:0] release_block(int off);
      int r;
      int bud;
      if (off >= pool_sz || !pg_used[off]) return ST_INVAL;
      r = pg_rank[off];
      if (r < 1 || r > NRANKS || (off & (rank_span(r) - 1)) != 0) return ST_INVAL;
      mark_pages(off, r, 0);
      while (r < NRANKS) begin
         bud = off ^ rank_span(r);
         if (bud + rank_span(r) > pool_sz || bud >= NPAGES) break;
         if (pg_used[bud] || pg_rank[bud] != r) break;
         list_drop(bud, r);
         off = off & ~rank_span(r);
         r++;
         mark_pages(off, r, -1);
      end
      list_add(off, r);
      return ST_OK;
   endfunction

   // Applies one request to the model, keeps the table of live allocations
   // up to date and returns the response the block should give.
   function automatic rsp_type apply_request(logic [FUNC_W-1:0] func, int rank, int page);
      rsp_type res;
      int      got;
      res = '{ST_INVAL, '0, '0};
      case (func)
         FUNC_INIT: begin
            rebuild_pool();
            live_blocks.delete();
            res.status = ST_OK;
         end
         FUNC_ALLOC: begin
            res.status = take_block(rank, got);
            if (res.status == ST_OK) begin
               res.block_page = got[BLOCK_W-1:0];
               live_blocks.push_back(got);
            end
         end
         FUNC_FREE: begin
            res.status = release_block(page);
            if (res.status == ST_OK)
               foreach (live_blocks[i])
                  if (live_blocks[i] == page) begin
                     live_blocks.delete(i);
                     break;
                  end
         end
         FUNC_QRANK:
            if (page < pool_sz) begin
               res.status = ST_OK;
               res.value  = pg_rank[page][VALUE_W-1:0];
            end
         FUNC_QCOUNT:
            if (rank >= 1 && rank <= NRANKS) begin
               res.status = ST_OK;
               res.value  = nfree[rank-1][VALUE_W-1:0];
            end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
      errors++;
   endtask

   // Leaves req_tvalid high after the transfer so that back-to-back requests
   // keep it high; a following gap or the end lowers it.
   task automatic send_req(logic [FUNC_W-1:0] func, int rank, int page, bit typed,
                           rsp_type typed_rsp);
      rsp_type res;
      while (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {6'b0, page[PAGE_W-1:0], rank[RANK_W-1:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = apply_request(func, rank, page);
      pending_rsp.push_back(typed ? typed_rsp : res);
      sent++;
      if (sent < 520) begin
         tx_gap_pct = 14;
         rx_gap_pct = 88;
      end else if (sent < 1040) begin
         tx_gap_pct = 88;
         rx_gap_pct = 14;
      end else begin
         tx_gap_pct = 0;
         rx_gap_pct = 0;
      end
      @(negedge clock);
   endtask

   task automatic write_pool_size(int pages);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= pages[CFG_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pool_cfg = pages;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random();
      int   pick;
      int   rank;
      int   page;
      logic [FUNC_W-1:0] func;
      pick = $urandom_range(0, 99);
      rank = 0;
      page = $urandom_range(0, 8191);
      if (pick < 40) begin
         func = FUNC_ALLOC;
         pick = $urandom_range(0, 99);
         if (pick < 80)      rank = $urandom_range(1, 4);
         else if (pick < 95) rank = $urandom_range(5, 8);
         else if (pick < 98) rank = $urandom_range(9, NRANKS);
         else                rank = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
      end else if (pick < 70) begin
         func = FUNC_FREE;
         pick = $urandom_range(0, 99);
         if (live_blocks.size() != 0 && pick < 85)
            page = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
         else if (live_blocks.size() != 0 && pick < 93)
            page = live_blocks[$urandom_range(0, live_blocks.size() - 1)] + 1;
      end else if (pick < 82) begin
         func = FUNC_QRANK;
         if (pool_sz > 0 && $urandom_range(0, 3) != 0) page = $urandom_range(0, pool_sz - 1);
      end else if (pick < 95) begin
         func = FUNC_QCOUNT;
         rank = ($urandom_range(0, 4) != 0) ? $urandom_range(1, NRANKS)
                                            : $urandom_range(0, 31);
      end else if (pick < 98) begin
         func = FUNC_BAD_LO + FUNC_W'($urandom_range(0, 2));
         rank = $urandom_range(0, 31);
      end else begin
         func = FUNC_INIT;
      end
      send_req(func, rank, page, 1'b0, '{ST_OK, '0, '0});
   endtask

   row_type directed [27] = '{
      '{FUNC_QRANK,  0,  0,    1, ST_INVAL, 0, 0},
      '{FUNC_FREE,   0,  0,    1, ST_INVAL, 0, 0},
      '{FUNC_ALLOC,  1,  0,    1, ST_NOSPC, 0, 0},
      '{FUNC_QCOUNT, 0,  0,    1, ST_INVAL, 0, 0},
      '{FUNC_QCOUNT, 17, 0,    1, ST_INVAL, 0, 0},
      '{FUNC_ALLOC,  31, 0,    1, ST_INVAL, 0, 0},
      '{FUNC_BAD_LO, 1,  0,    1, ST_INVAL, 0, 0},
      '{FUNC_BAD_HI, 31, 8191, 1, ST_INVAL, 0, 0},
      '{FUNC_INIT,   0,  0,    1, ST_OK,    0, 0},
      '{FUNC_QCOUNT, 13, 0,    1, ST_OK,    0, 1},
      '{FUNC_QCOUNT, 16, 0,    1, ST_OK,    0, 0},
      '{FUNC_ALLOC,  1,  0,    1, ST_OK,    0, 0},
      '{FUNC_QRANK,  0,  0,    0, ST_OK,    0, 0},
      '{FUNC_QCOUNT, 1,  0,    0, ST_OK,    0, 0},
      '{FUNC_FREE,   0,  1,    1, ST_INVAL, 0, 0},
      '{FUNC_ALLOC,  2,  0,    0, ST_OK,    0, 0},
      '{FUNC_FREE,   0,  3,    1, ST_INVAL, 0, 0},
      '{FUNC_FREE,   0,  2,    0, ST_OK,    0, 0},
      '{FUNC_FREE,   0,  0,    0, ST_OK,    0, 0},
      '{FUNC_QCOUNT, 13, 0,    1, ST_OK,    0, 1},
      '{FUNC_QRANK,  0,  4095, 0, ST_OK,    0, 0},
      '{FUNC_QRANK,  0,  4096, 1, ST_INVAL, 0, 0},
      '{FUNC_FREE,   0,  8191, 1, ST_INVAL, 0, 0},
      '{FUNC_ALLOC,  16, 0,    1, ST_NOSPC, 0, 0},
      '{FUNC_ALLOC,  13, 0,    1, ST_OK,    0, 0},
      '{FUNC_ALLOC,  1,  0,    1, ST_NOSPC, 0, 0},
      '{FUNC_FREE,   0,  0,    1, ST_OK,    0, 0}
   };

   int phase_pool [8];

   initial begin
      int n_items;
      errors     = 0;
      sent       = 0;
      tx_gap_pct = 14;
      rx_gap_pct = 88;
      pool_cfg   = 0;
      pool_sz    = 0;
      clear_pool();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // An oversized pool clamps to the full pool for the directed part.
      write_pool_size(8191);
      foreach (directed[i])
         send_req(directed[i].func, directed[i].rank, directed[i].page, directed[i].typed,
                  '{directed[i].status, directed[i].block_page, directed[i].value});

      phase_pool = '{1, 4096, 300, $urandom_range(2, 4095), 0, 1537, 4095, 8191};
      foreach (phase_pool[p]) begin
         write_pool_size(phase_pool[p]);
         send_req(FUNC_INIT, 0, 0, 1'b0, '{ST_OK, '0, '0});
         n_items = (phase_pool[p] == 0) ? 30 : 215;
         for (int k = 0; k < n_items; k++) begin
            if (sent == 700) begin
               req_tvalid <= 1'b0;
               while (pending_rsp.size() != 0) @(negedge clock);
            end
            send_random();
         end
      end
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0)
         $display("** buddy_page_allocator: PASSED **");
      else
         $display("** buddy_page_allocator: FAILED **");
      $finish;
   end

   // Receiver: random stalls plus one long hold-off while requests keep coming.
   always @(negedge clock) begin
      if (!hold_done && sent >= 150) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(rx_gap_pct > 0 && $urandom_range(0, 99) < rx_gap_pct);
      end
   end

   initial begin
      hold_done = 1'b0;
      hold_left = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response transfer", 1, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[1:0] !== want.status)
               report_mismatch("status", rsp_tdata[1:0], want.status);
            if (rsp_tdata[13:2] !== want.block_page)
               report_mismatch("block_page", rsp_tdata[13:2], want.block_page);
            if (rsp_tdata[26:14] !== want.value)
               report_mismatch("value", rsp_tdata[26:14], want.value);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_CAP) begin
         $display("timeout: no transfer for %0d cycles", IDLE_CAP);
         $display("** buddy_page_allocator: FAILED **");
         $finish;
      end
   end

   initial idle_cycles = 0;

endmodule

@@ files.f @@
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_lists.sv
sv/buddy_page_allocator.sv
verif/buddy_page_allocator_tb.sv
